FILE: rtl/core/ugb_pkg.sv
// ----------------------------------------------------------------------------
// ugb_pkg
// shared types and codes of the uniform grid broadphase
// ----------------------------------------------------------------------------
`default_nettype none

package ugb_pkg;

  // one request
  typedef struct packed {
    logic [2:0]         action;
    logic [4:0]         object_id;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic [15:0]        category_bits;
    logic [15:0]        mask_bits;
  } ugb_in_t;

  // one result
  typedef struct packed {
    logic [4:0] partner_id;
    logic       found;
    logic       last;
    logic       status;
  } ugb_out_t;

  // action codes
  localparam logic [2:0] ACT_PLACE   = 3'd0;
  localparam logic [2:0] ACT_REMOVE  = 3'd1;
  localparam logic [2:0] ACT_QUERY   = 3'd2;
  localparam logic [2:0] ACT_FIND    = 3'd3;
  localparam logic [2:0] ACT_CLR_IGN = 3'd4;

  // register indexes
  localparam logic [2:0] REG_GRID_COLS  = 3'd0;
  localparam logic [2:0] REG_GRID_ROWS  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X   = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd3;
  localparam logic [2:0] REG_CELL_SHIFT = 3'd4;

  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_SLOT = 1'b1;

  // what a cell walk does to each cell
  typedef enum logic [1:0] {
    WOP_CLR,
    WOP_SET,
    WOP_GATHER
  } walk_op_e;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     calc;
    logic     walk_init;
    logic     walk_src_new;
    walk_op_e walk_op;
    logic     walk_rd;
    logic     walk_wr;
    logic     slot_write;
    logic     slot_drop;
    logic     ign_clear;
    logic     ign_upd;
    logic     single;
    logic     single_status;
    logic     emit_init;
    logic     emit_step;
    logic     init_step;
  } ugb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] action;
    logic       id_oob;
    logic       id_valid;
    logic       walk_empty;
    logic       walk_last;
    logic       sel_empty;
    logic       init_done;
  } ugb_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/ugb_ctrl.sv
// ----------------------------------------------------------------------------
// ugb_ctrl
// sequencer of the broadphase: decode, cell walks, result scan
// ----------------------------------------------------------------------------
`default_nettype none

module ugb_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  ugb_pkg::ugb_stat_t stat_i,
  output ugb_pkg::ugb_cmd_t  cmd_o,
  output logic               busy_o
);
  import ugb_pkg::*;

  typedef enum logic [7:0] {
    S_INIT    = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_DEC     = 8'b0000_0100,
    S_DISP    = 8'b0000_1000,
    S_WALK_RD = 8'b0001_0000,
    S_WALK_WR = 8'b0010_0000,
    S_FIN     = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_e;

  state_e   state_q, state_d;
  walk_op_e op_q, op_d;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cmd_o       = '0;
    cmd_o.walk_op = op_q;
    case (state_q)
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (stat_i.init_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_DISP;
      end
      S_DISP: begin
        case (stat_i.action)
          ACT_QUERY: begin
            cmd_o.walk_init    = 1'b1;
            cmd_o.walk_src_new = 1'b1;
            op_d               = WOP_GATHER;
            state_d            = S_WALK_RD;
          end
          ACT_CLR_IGN: begin
            cmd_o.ign_clear     = 1'b1;
            cmd_o.single        = 1'b1;
            cmd_o.single_status = STATUS_OK;
            state_d             = S_IDLE;
          end
          ACT_PLACE, ACT_REMOVE, ACT_FIND: begin
            if (stat_i.id_oob) begin
              cmd_o.single        = 1'b1;
              cmd_o.single_status = STATUS_NO_SLOT;
              state_d             = S_IDLE;
            end else if (stat_i.action == ACT_PLACE) begin
              cmd_o.walk_init = 1'b1;
              state_d         = S_WALK_RD;
              if (stat_i.id_valid) begin
                op_d = WOP_CLR;
              end else begin
                cmd_o.slot_write   = 1'b1;
                cmd_o.walk_src_new = 1'b1;
                op_d               = WOP_SET;
              end
            end else if (!stat_i.id_valid) begin
              cmd_o.single        = 1'b1;
              cmd_o.single_status = STATUS_NO_SLOT;
              state_d             = S_IDLE;
            end else begin
              cmd_o.walk_init = 1'b1;
              op_d    = (stat_i.action == ACT_REMOVE) ? WOP_CLR : WOP_GATHER;
              state_d = S_WALK_RD;
            end
          end
          default: begin
            cmd_o.single        = 1'b1;
            cmd_o.single_status = STATUS_OK;
            state_d             = S_IDLE;
          end
        endcase
      end
      S_WALK_RD: begin
        if (stat_i.walk_empty) begin
          state_d = S_FIN;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d       = S_WALK_WR;
        end
      end
      S_WALK_WR: begin
        cmd_o.walk_wr = 1'b1;
        state_d = stat_i.walk_last ? S_FIN : S_WALK_RD;
      end
      S_FIN: begin
        case (op_q)
          WOP_CLR: begin
            if (stat_i.action == ACT_PLACE) begin
              cmd_o.slot_write   = 1'b1;
              cmd_o.walk_init    = 1'b1;
              cmd_o.walk_src_new = 1'b1;
              op_d               = WOP_SET;
              state_d            = S_WALK_RD;
            end else begin
              cmd_o.slot_drop     = 1'b1;
              cmd_o.single        = 1'b1;
              cmd_o.single_status = STATUS_OK;
              state_d             = S_IDLE;
            end
          end
          WOP_SET: begin
            cmd_o.single        = 1'b1;
            cmd_o.single_status = STATUS_OK;
            state_d             = S_IDLE;
          end
          WOP_GATHER: begin
            cmd_o.emit_init = 1'b1;
            cmd_o.ign_upd   = (stat_i.action == ACT_FIND);
            state_d         = S_EMIT;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (stat_i.sel_empty) state_d = S_IDLE;
        else cmd_o.emit_step = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      op_q    <= WOP_GATHER;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/ugb_dpath.sv
// ----------------------------------------------------------------------------
// ugb_dpath
// broadphase datapath: config, slot table, cell memory, scan and result
// ----------------------------------------------------------------------------
`default_nettype none

module ugb_dpath #(
  parameter int MAX_OBJECTS = 32,
  parameter int MAX_COLS    = 32,
  parameter int MAX_ROWS    = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  ugb_pkg::ugb_in_t            item_i,
  input  wire                         cfg_we_i,
  input  wire [ugb_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  wire [ugb_pkg::CFG_DW-1:0]   cfg_data_i,
  input  ugb_pkg::ugb_cmd_t           cmd_i,
  output ugb_pkg::ugb_stat_t          stat_o,
  output logic                        res_valid_o,
  output ugb_pkg::ugb_out_t           res_o
);
  import ugb_pkg::*;

  localparam int NS    = (MAX_OBJECTS < 32) ? MAX_OBJECTS : 32;
  localparam int SW    = $clog2(NS);
  localparam int CB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // cell index: difference above zero, shifted, saturated at lim
  function automatic logic [6:0] cell_of(logic [31:0] b, logic [31:0] o,
                                         logic [4:0] sh, logic [6:0] lim);
    logic signed [32:0] d;
    logic [31:0]        q;
    d = $signed({b[31], b}) - $signed({o[31], o});
    q = d[31:0] >> sh;
    if (d[32] || (d == '0)) return 7'd0;
    else if (q > {25'd0, lim}) return lim;
    else return q[6:0];
  endfunction

  // configuration
  logic [5:0]  cols_q, rows_q;
  logic [31:0] org_x_q, org_y_q;
  logic [4:0]  shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= 6'd20;
      rows_q  <= 6'd20;
      org_x_q <= '0;
      org_y_q <= '0;
      shift_q <= 5'd15;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_COLS:  cols_q  <= cfg_data_i[5:0];
        REG_GRID_ROWS:  rows_q  <= cfg_data_i[5:0];
        REG_ORIGIN_X:   org_x_q <= cfg_data_i;
        REG_ORIGIN_Y:   org_y_q <= cfg_data_i;
        REG_CELL_SHIFT: shift_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic [6:0] col_lim, row_lim;
  always_comb begin
    if (cols_q == '0) col_lim = 7'd0;
    else if ({1'b0, cols_q} > 7'(MAX_COLS)) col_lim = 7'(MAX_COLS - 1);
    else col_lim = {1'b0, cols_q} - 7'd1;
    if (rows_q == '0) row_lim = 7'd0;
    else if ({1'b0, rows_q} > 7'(MAX_ROWS)) row_lim = 7'(MAX_ROWS - 1);
    else row_lim = {1'b0, rows_q} - 7'd1;
  end

  // request and its cell range
  ugb_in_t       item_q;
  logic [CB-1:0] nc0_q, nc1_q;
  logic [RB-1:0] nr0_q, nr1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.calc) begin
      nc0_q <= CB'(cell_of(item_q.box_min_x, org_x_q, shift_q, col_lim));
      nc1_q <= CB'(cell_of(item_q.box_max_x, org_x_q, shift_q, col_lim));
      nr0_q <= RB'(cell_of(item_q.box_min_y, org_y_q, shift_q, row_lim));
      nr1_q <= RB'(cell_of(item_q.box_max_y, org_y_q, shift_q, row_lim));
    end
  end

  logic [SW-1:0] id;
  assign id = item_q.object_id[SW-1:0];

  // slot table
  logic [NS-1:0] valid_q, ign_q;
  logic [15:0]   cat_q [NS];
  logic [15:0]   msk_q [NS];
  logic [CB-1:0] clo_q [NS];
  logic [CB-1:0] chi_q [NS];
  logic [RB-1:0] rlo_q [NS];
  logic [RB-1:0] rhi_q [NS];

  logic multi;
  assign multi = (clo_q[id] != chi_q[id]) || (rlo_q[id] != rhi_q[id]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.slot_write) begin
      cat_q[id] <= item_q.category_bits;
      msk_q[id] <= item_q.mask_bits;
      clo_q[id] <= nc0_q;
      chi_q[id] <= nc1_q;
      rlo_q[id] <= nr0_q;
      rhi_q[id] <= nr1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ign_q   <= '0;
    end else begin
      if (cmd_i.slot_write) valid_q[id] <= 1'b1;
      if (cmd_i.slot_drop) begin
        valid_q[id] <= 1'b0;
        ign_q[id]   <= 1'b0;
      end
      if (cmd_i.ign_clear) ign_q <= '0;
      if (cmd_i.ign_upd && multi) ign_q[id] <= 1'b1;
    end
  end

  // cell walk
  logic [CB-1:0] wc0_q, wc1_q, c_q;
  logic [RB-1:0] wr0_q, wr1_q, r_q;
  logic [NS-1:0] acc_q, rd_q;
  logic [AW-1:0] cell_addr, ini_q;

  assign cell_addr = AW'(32'(r_q) * 32'(MAX_COLS) + 32'(c_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      wc0_q <= cmd_i.walk_src_new ? nc0_q : clo_q[id];
      wc1_q <= cmd_i.walk_src_new ? nc1_q : chi_q[id];
      wr0_q <= cmd_i.walk_src_new ? nr0_q : rlo_q[id];
      wr1_q <= cmd_i.walk_src_new ? nr1_q : rhi_q[id];
      c_q   <= cmd_i.walk_src_new ? nc0_q : clo_q[id];
      r_q   <= cmd_i.walk_src_new ? nr0_q : rlo_q[id];
      acc_q <= '0;
    end else if (cmd_i.walk_wr) begin
      acc_q <= acc_q | rd_q;
      if (c_q == wc1_q) begin
        c_q <= wc0_q;
        r_q <= r_q + RB'(1);
      end else begin
        c_q <= c_q + CB'(1);
      end
    end
  end

  // cell occupancy memory
  logic [NS-1:0] mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [NS-1:0] mem_wdata;
  logic [NS-1:0] id_bit;

  assign id_bit = NS'(1) << id;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr;
    mem_wdata = rd_q;
    if (cmd_i.init_step) begin
      mem_we    = 1'b1;
      mem_waddr = ini_q;
      mem_wdata = '0;
    end else if (cmd_i.walk_wr) begin
      case (cmd_i.walk_op)
        WOP_SET: begin
          mem_we    = 1'b1;
          mem_wdata = rd_q | id_bit;
        end
        WOP_CLR: begin
          mem_we    = 1'b1;
          mem_wdata = rd_q & ~id_bit;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.walk_rd) rd_q <= mem[cell_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ini_q <= '0;
    else if (cmd_i.init_step) ini_q <= ini_q + AW'(1);
  end

  // partner selection
  logic [NS-1:0] sel;
  logic [15:0]   qmask;
  always_comb begin
    qmask = (item_q.action == ACT_FIND) ? msk_q[id] : item_q.mask_bits;
    for (int i = 0; i < NS; i++) begin
      if (item_q.action == ACT_FIND)
        sel[i] = acc_q[i] && valid_q[i] && !ign_q[i] && (i != int'(id)) &&
                 (|(qmask & cat_q[i])) && (|(msk_q[i] & cat_q[id]));
      else
        sel[i] = acc_q[i] && valid_q[i] && (|(qmask & cat_q[i]));
    end
  end

  logic [NS-1:0] sel_q, scan_bit;
  logic [SW-1:0] scan_q;
  assign scan_bit = NS'(1) << scan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= '0;
      scan_q      <= '0;
      res_valid_o <= 1'b0;
    end else begin
      if (cmd_i.single) begin
        res_valid_o <= 1'b1;
      end else if (cmd_i.emit_init) begin
        sel_q       <= sel;
        scan_q      <= '0;
        res_valid_o <= (sel == '0);
      end else if (cmd_i.emit_step) begin
        scan_q      <= scan_q + SW'(1);
        res_valid_o <= sel_q[scan_q];
        if (sel_q[scan_q]) sel_q[scan_q] <= 1'b0;
      end else begin
        res_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.single) begin
      res_o <= '{partner_id: 5'd0, found: 1'b0, last: 1'b1,
                 status: cmd_i.single_status};
    end else if (cmd_i.emit_init) begin
      res_o <= '{partner_id: 5'd0, found: 1'b0, last: 1'b1, status: STATUS_OK};
    end else if (cmd_i.emit_step) begin
      res_o <= '{partner_id: 5'(scan_q), found: 1'b1,
                 last: ((sel_q & ~scan_bit) == '0), status: STATUS_OK};
    end
  end

  // status to the sequencer
  assign stat_o.action     = item_q.action;
  assign stat_o.id_oob     = ({1'b0, item_q.object_id} >= 6'(NS));
  assign stat_o.id_valid   = valid_q[id];
  assign stat_o.walk_empty = (wc0_q > wc1_q) || (wr0_q > wr1_q);
  assign stat_o.walk_last  = (c_q == wc1_q) && (r_q == wr1_q);
  assign stat_o.sel_empty  = (sel_q == '0);
  assign stat_o.init_done  = (ini_q == AW'(DEPTH - 1));

endmodule

`default_nettype wire

FILE: rtl/core/uniform_grid_broadphase_top.sv
// ----------------------------------------------------------------------------
// uniform_grid_broadphase_top
// 2d uniform grid broadphase: place, remove, box query, partner search
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// request   in         start & !busy          item_i (ugb_in_t)
// result    out        res_valid_o, 1 cycle   res_o (ugb_out_t)
// config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// one request at a time; it is accepted, decoded (box clamped to the grid)
// and dispatched, then each cell walk reads and writes each cell in turn and
// then closes (an empty range goes straight to the close); place clears the
// old range of a slot in use, then sets the new range; query/find then scan
// the slots up to the highest selected one and finish; the cell memory
// read-modify-write sets the pace
// after reset all MAX_COLS*MAX_ROWS cells of the cell memory are swept to
// zero with busy high; config writes are taken meanwhile
// results leave through a register, one per strobe; the receiver cannot stall
// ----------------------------------------------------------------------------
`default_nettype none

module uniform_grid_broadphase_top #(
  parameter int MAX_OBJECTS = 32,
  parameter int MAX_COLS    = 32,
  parameter int MAX_ROWS    = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  output logic                        busy,
  input  ugb_pkg::ugb_in_t            item_i,
  output logic                        res_valid_o,
  output ugb_pkg::ugb_out_t           res_o,
  input  wire                         cfg_we_i,
  input  wire [ugb_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  wire [ugb_pkg::CFG_DW-1:0]   cfg_data_i
);
  import ugb_pkg::*;

  ugb_cmd_t  cmd;
  ugb_stat_t stat;

  // sequencer: decode, walks over cells, result scan
  ugb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // config, slot table, occupancy memory and result register
  ugb_dpath #(
    .MAX_OBJECTS (MAX_OBJECTS),
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // an accepted request keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request accepted but not busy");

  // more results of the request follow a non-final one
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |-> busy) else $error("request ended early");

  // a result that names no partner ends its request
  a_nofind_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.found) |-> res_o.last) else $error("empty result not last");

  // an error result carries no partner
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status) |-> (!res_o.found && res_o.partner_id == 5'd0))
    else $error("error result with partner");

endmodule

`default_nettype wire
